### hw/rtl/cordic_sine_cosine_tangent_defines.svh
// Assertion macros shared by the CORDIC block.
`ifndef CORDIC_SINE_COSINE_TANGENT_DEFINES_SVH
`define CORDIC_SINE_COSINE_TANGENT_DEFINES_SVH

// Checks that an implication holds at each rising clock edge outside reset.
`define CST_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/cst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cst_pkg;
	localparam int MaxIterations = 32;
	localparam int TableSize = 48;
	localparam int IterLimit = (MaxIterations < TableSize) ? MaxIterations : TableSize;
	localparam int IdxW = $clog2(IterLimit);
	// x and y carry two guard bits above Q2.30; z is Q.24 degrees.
	localparam int XyW = 34;
	localparam int ZW = 34;
	localparam logic [XyW-1:0] OneQ230 = XyW'(64'sd1073741824);

	localparam logic [31:0] ATAN_DEG_Q24 [TableSize] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
		32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
		32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
		32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
		32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0,
		32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
		32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
	};

	localparam logic [31:0] INV_GAIN_Q230 [TableSize] = '{
		32'd759250125, 32'd679093957, 32'd658817909, 32'd653730436, 32'd652457347,
		32'd652138997, 32'd652059405, 32'd652039507, 32'd652034532, 32'd652033289,
		32'd652032978, 32'd652032900, 32'd652032881, 32'd652032876, 32'd652032874,
		32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874,
		32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874,
		32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874,
		32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874,
		32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874,
		32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874, 32'd652032874,
		32'd652032874, 32'd652032874, 32'd652032874
	};

	// State of one item as it moves down the rotation pipeline.
	typedef struct packed {
		logic signed [XyW-1:0] x;
		logic signed [XyW-1:0] y;
		logic signed [ZW-1:0]  z;
		logic [IdxW-1:0]       last;
	} rot_t;

	// Operands of the tangent divider.
	typedef struct packed {
		logic signed [31:0] cos_v;
		logic signed [31:0] sin_v;
	} trig_t;
endpackage
`default_nettype wire

### hw/rtl/cst_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cst_angle_if;
	logic valid;
	logic ready;
	logic signed [23:0] angle_deg;
	modport source (output valid, output angle_deg, input ready);
	modport sink (input valid, input angle_deg, output ready);
endinterface

interface cst_result_if;
	logic valid;
	logic ready;
	logic signed [31:0] cos_val;
	logic signed [31:0] sin_val;
	logic signed [31:0] tan_val;
	logic tan_overflow;
	modport source (output valid, output cos_val, output sin_val, output tan_val,
		output tan_overflow, input ready);
	modport sink (input valid, input cos_val, input sin_val, input tan_val,
		input tan_overflow, output ready);
endinterface

interface cst_cfg_if;
	logic valid;
	logic ready;
	logic [4:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/cst_rot_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// One CORDIC micro-rotation at a fixed iteration index; a pass-through once past last.
// The index comes in as a tied-off port, so shifts and the table lookup reduce to wiring.
module cst_rot_stage import cst_pkg::*; (
	input  wire  [IdxW-1:0] iter,
	input  wire  rot_t      din,
	output rot_t            dout
);
	logic signed [ZW-1:0] atan_v;
	logic signed [XyW-1:0] dx;
	logic signed [XyW-1:0] dy;
	logic active;

	assign atan_v = ZW'(signed'({1'b0, ATAN_DEG_Q24[iter]}));
	assign dx = din.y >>> iter;
	assign dy = din.x >>> iter;
	assign active = iter <= din.last;

	always_comb begin
		dout = din;
		if (active) begin
			if (!din.z[ZW-1]) begin
				dout.x = din.x - dx;
				dout.y = din.y + dy;
				dout.z = din.z - atan_v;
			end else begin
				dout.x = din.x + dx;
				dout.y = din.y - dy;
				dout.z = din.z + atan_v;
			end
		end
	end
endmodule
`default_nettype wire

### hw/rtl/cst_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider: tangent = (sin << 16) / cos, truncated, saturated.
// One quotient bit per stage, four bits per register stage.
module cst_divider import cst_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         en,
	input  wire         in_valid,
	input  wire  trig_t in_data,
	output logic        out_valid,
	output trig_t       out_data,
	output logic [31:0] tan_val,
	output logic        tan_overflow
);
	localparam int QW = 48;
	localparam int BitsPerStage = 4;
	localparam int NStg = QW / BitsPerStage;

	typedef struct packed {
		logic [QW-1:0] num;
		logic [QW-1:0] rem;
		logic [31:0]   den;
		logic          neg;
		logic          zero;
		trig_t         trig;
	} div_t;

	div_t stg_s1 [NStg+1];
	logic vld_s1 [NStg+1];
	div_t first;
	logic [31:0] sin_mag;
	logic [31:0] cos_mag;

	assign sin_mag = in_data.sin_v[31] ? 32'(-in_data.sin_v) : in_data.sin_v;
	assign cos_mag = in_data.cos_v[31] ? 32'(-in_data.cos_v) : in_data.cos_v;

	always_comb begin
		first.num = {sin_mag[31:0], 16'd0};
		first.rem = '0;
		first.den = cos_mag;
		first.neg = in_data.sin_v[31] ^ in_data.cos_v[31];
		first.zero = (in_data.cos_v == 32'sd0);
		first.trig = in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1[0] <= 1'b0;
		end else if (en) begin
			vld_s1[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			stg_s1[0] <= first;
		end
	end

	for (genvar g = 0; g < NStg; g++) begin : g_div
		div_t nxt;
		always_comb begin
			logic [QW:0] trial;
			nxt = stg_s1[g];
			for (int b = 0; b < BitsPerStage; b++) begin
				trial = {nxt.rem, nxt.num[QW-1]};
				nxt.num = {nxt.num[QW-2:0], 1'b0};
				if (trial >= {17'd0, nxt.den}) begin
					trial = trial - {17'd0, nxt.den};
					nxt.num[0] = 1'b1;
				end
				nxt.rem = trial[QW-1:0];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[g+1] <= 1'b0;
			end else if (en) begin
				vld_s1[g+1] <= vld_s1[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				stg_s1[g+1] <= nxt;
			end
		end
	end

	// After all stages, num holds the magnitude of the quotient.
	always_comb begin
		div_t fin;
		fin = stg_s1[NStg];
		out_valid = vld_s1[NStg];
		out_data = fin.trig;
		tan_overflow = 1'b0;
		if (fin.zero) begin
			tan_val = fin.trig.sin_v[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			tan_overflow = 1'b1;
		end else if (fin.neg) begin
			if (fin.num > 48'h8000_0000) begin
				tan_val = 32'h8000_0000;
				tan_overflow = 1'b1;
			end else begin
				tan_val = 32'(-fin.num[31:0]);
			end
		end else if (fin.num > 48'h7FFF_FFFF) begin
			tan_val = 32'h7FFF_FFFF;
			tan_overflow = 1'b1;
		end else begin
			tan_val = fin.num[31:0];
		end
	end
endmodule
`default_nettype wire

### hw/rtl/cordic_sine_cosine_tangent.sv
`timescale 1ns / 1ps
`default_nettype none
// CORDIC sine, cosine and tangent of an angle in degrees (signed Q.16).
// Channels: angle (sink) carries angle_deg; result (source) carries cos_val and
// sin_val in Q2.30, tan_val in Q16.16 and tan_overflow; cfg (sink) writes
// last_iteration, the index of the final rotation, and is always ready.
// Write cfg only while no item is in flight.
// Throughput: one transfer per cycle unless the receiver stalls. Registers: 1 input register, one register
// per four rotations (eight), one clamp register, thirteen divider registers and
// an output register.
// The divider, one quotient bit per step, sets the depth.
// The whole pipeline advances as one unit; when the receiver stalls with a
// result waiting, every stage holds and the angle channel deasserts ready
// until the output slot frees, so nothing is lost or repeated.
// Reset clears all valid bits and sets last_iteration to 30.
`include "cordic_sine_cosine_tangent_defines.svh"
module cordic_sine_cosine_tangent import cst_pkg::*; (
	input wire clk,
	input wire arst_n,
	cst_angle_if.sink   angle,
	cst_result_if.source result,
	cst_cfg_if.sink     cfg
);
	localparam int RotPerStage = 4;
	localparam int NRot = (IterLimit + RotPerStage - 1) / RotPerStage;

	logic [4:0] last_iteration_q;
	logic en;
	logic out_valid_q;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_iteration_q <= 5'd30;
		end else if (cfg.valid) begin
			last_iteration_q <= cfg.data;
		end
	end

	assign en = !out_valid_q || result.ready;
	assign angle.ready = en;

	// Input stage: seed x with the inverse gain and widen z.
	rot_t rot_s1 [NRot+1];
	logic rvld_s1 [NRot+1];
	rot_t seed;
	always_comb begin
		logic [IdxW-1:0] lst;
		lst = ({1'b0, last_iteration_q} > 6'(IterLimit - 1)) ? IdxW'(IterLimit - 1)
			: IdxW'(last_iteration_q);
		seed.last = lst;
		seed.x = XyW'(signed'({1'b0, INV_GAIN_Q230[lst]}));
		seed.y = '0;
		seed.z = {{(ZW-32){angle.angle_deg[23]}}, angle.angle_deg, 8'd0};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1[0] <= 1'b0;
		end else if (en) begin
			rvld_s1[0] <= angle.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1[0] <= seed;
		end
	end

	for (genvar s = 0; s < NRot; s++) begin : g_rot
		rot_t chain [RotPerStage+1];
		assign chain[0] = rot_s1[s];
		for (genvar k = 0; k < RotPerStage; k++) begin : g_it
			if (s * RotPerStage + k < IterLimit) begin : g_on
				cst_rot_stage u_rot (
					.iter(IdxW'(s * RotPerStage + k)), .din(chain[k]), .dout(chain[k+1]));
			end else begin : g_off
				assign chain[k+1] = chain[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rvld_s1[s+1] <= 1'b0;
			end else if (en) begin
				rvld_s1[s+1] <= rvld_s1[s];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rot_s1[s+1] <= chain[RotPerStage];
			end
		end
	end

	// Clamp stage.
	trig_t trig_s2;
	logic vld_s2;
	function automatic logic [31:0] clamp_unit(input logic signed [XyW-1:0] v);
		if (v > signed'(OneQ230)) begin
			return 32'h4000_0000;
		end else if (v < -signed'(OneQ230)) begin
			return 32'hC000_0000;
		end
		return v[31:0];
	endfunction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= rvld_s1[NRot];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			trig_s2.cos_v <= clamp_unit(rot_s1[NRot].x);
			trig_s2.sin_v <= clamp_unit(rot_s1[NRot].y);
		end
	end

	logic div_valid;
	trig_t div_trig;
	logic [31:0] div_tan;
	logic div_ovf;
	cst_divider u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s2), .in_data(trig_s2),
		.out_valid(div_valid), .out_data(div_trig), .tan_val(div_tan),
		.tan_overflow(div_ovf));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= div_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			result.cos_val <= div_trig.cos_v;
			result.sin_val <= div_trig.sin_v;
			result.tan_val <= div_tan;
			result.tan_overflow <= div_ovf;
		end
	end
	assign result.valid = out_valid_q;

	`CST_ASSERT_NEXT(a_hold_stall, out_valid_q && !result.ready, out_valid_q && $stable(result.cos_val), "result dropped during stall")
	`CST_ASSERT_IMPL(a_ready_free, !out_valid_q, angle.ready, "pipeline stalled with empty output")
	`CST_ASSERT_IMPL(a_zero_cos, result.valid && result.cos_val == 32'sd0, result.tan_overflow, "zero cosine not flagged")
endmodule
`default_nettype wire
